[hdl/tsa_pkg.sv]
// Shared types, widths and constants for the triangle solid angle pipeline.
package tsa_pkg;

  localparam int COORD_W   = 32;  // Q15.16 coordinates
  localparam int DIFF_W    = 33;  // vertex minus observer, exact
  localparam int R_W       = 20;  // block-normalized components
  localparam int R_TOP     = 19;  // largest magnitude lands in [2^18, 2^19)
  localparam int PROD_W    = 40;  // component products
  localparam int CROSS_W   = 41;  // cross product components
  localparam int DOT_W     = 42;  // dot products
  localparam int NUMP_W    = 61;  // r * cross partials
  localparam int WIDE_W    = 64;  // numerator / denominator
  localparam int MAG_W     = 32;  // CORDIC magnitude in/out
  localparam int LEN_W     = 22;  // vector lengths
  localparam int LEN_GUARD = 10;  // guard bits for the length passes
  localparam int CORDIC_W  = 34;  // CORDIC x / y datapath
  localparam int ANG_W     = 36;  // Q30 angle accumulator
  localparam int ATAN_TOP  = 29;  // atan2 operands normalized into [2^28, 2^29)
  localparam int OUT_W     = 20;  // Q3.16 result

  localparam logic signed [30:0]      INV_GAIN_Q30 = 31'sd652032875;
  localparam logic signed [ANG_W-1:0] PI_Q30       = 36'sd3373259426;

  // configuration register indexes; the last code selects nothing
  typedef enum logic [1:0] {
    CFG_OBS_X = 2'd0,
    CFG_OBS_Y = 2'd1,
    CFG_OBS_Z = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_e;

  // round(atan(2^-i) * 2^30)
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
    32'd32,        32'd16,        32'd8,         32'd4,         32'd2,
    32'd1,         32'd0
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic signed [COORD_W-1:0] third_x;
    logic signed [COORD_W-1:0] third_y;
    logic signed [COORD_W-1:0] third_z;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] solid_angle;
    logic                    degenerate;
  } out_t;

  // Position of the highest set bit plus one; zero for zero.
  function automatic logic [6:0] bit_len(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

endpackage

[hdl/tsa_cordic_mag.sv]
// Pipelined vectoring CORDIC magnitude with gain compensation, one stage per step.
module tsa_cordic_mag #(
  parameter int STEPS = 20
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [tsa_pkg::MAG_W-1:0]    a_i,
  input  logic signed [tsa_pkg::MAG_W-1:0]    b_i,
  output logic signed [tsa_pkg::MAG_W-1:0]    mag_o
);

  localparam int XW = tsa_pkg::CORDIC_W;

  logic signed [XW-1:0]                x_q [STEPS+1];
  logic signed [XW-1:0]                y_q [STEPS+1];
  logic signed [tsa_pkg::WIDE_W-1:0]   prod_q;
  logic signed [tsa_pkg::WIDE_W-1:0]   rnd;
  logic signed [tsa_pkg::MAG_W-1:0]    mag_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= (a_i < 0) ? -XW'(a_i) : XW'(a_i);
      y_q[0] <= (b_i < 0) ? -XW'(b_i) : XW'(b_i);
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[k] > 0) begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
        end else begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
        end
      end
    end
  end

  // 1/K in Q30, rounded
  assign rnd = prod_q + (64'sd1 <<< 29);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= x_q[STEPS] * tsa_pkg::INV_GAIN_Q30;
      mag_q  <= rnd[61:30];
    end
  end

  assign mag_o = mag_q;

endmodule

[hdl/tsa_cordic_atan.sv]
// Pipelined vectoring CORDIC angle accumulator for atan2, one stage per step.
module tsa_cordic_atan #(
  parameter int STEPS = 20
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [tsa_pkg::CORDIC_W-1:0]  x_i,
  input  logic signed [tsa_pkg::CORDIC_W-1:0]  y_i,
  input  logic signed [tsa_pkg::ANG_W-1:0]     z_i,
  output logic signed [tsa_pkg::ANG_W-1:0]     z_o
);

  localparam int XW = tsa_pkg::CORDIC_W;
  localparam int ZW = tsa_pkg::ANG_W;

  logic signed [XW-1:0] x_q [STEPS+1];
  logic signed [XW-1:0] y_q [STEPS+1];
  logic signed [ZW-1:0] z_q [STEPS+1];

  assign x_q[0] = x_i;
  assign y_q[0] = y_i;
  assign z_q[0] = z_i;

  for (genvar k = 0; k < STEPS; k++) begin : g_iter
    logic signed [ZW-1:0] step_ang;
    assign step_ang = $signed({{(ZW-32){1'b0}}, tsa_pkg::ATAN_TAB[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[k] > 0) begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + step_ang;
        end else begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - step_ang;
        end
      end
    end
  end

  assign z_o = z_q[STEPS];

endmodule

[hdl/triangle_solid_angle.sv]
// Top level: signed solid angle of a triangle seen from a configurable observer.
//
// Streams one triangle per cycle. Each transaction carries three vertices in
// signed Q15.16; the observer position sits in three configuration registers
// (index 0..2 = x, y, z; index 3 is ignored). The result is
// 2*atan2(r1.(r2 x r3), |r1||r2||r3| + |r1|(r2.r3) + |r2|(r3.r1) + |r3|(r1.r2))
// in Q3.16 at the default FRAC_BITS, saturated to 20 bits, with a degenerate
// flag (and zero angle) when numerator and denominator are both zero.
// The pipeline holds two chained magnitude CORDIC pipelines for the lengths,
// the product tree for the denominator, and the atan2 CORDIC pipeline, each
// CORDIC step one stage. Throughput is one transaction per cycle. The whole
// pipeline advances together; it freezes only while a finished result is held
// by out_stall_i, and in_stall_o mirrors that condition.
module triangle_solid_angle #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tsa_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tsa_pkg::out_t out_data_o
);

  localparam int COORD_W   = tsa_pkg::COORD_W;
  localparam int DIFF_W    = tsa_pkg::DIFF_W;
  localparam int R_W       = tsa_pkg::R_W;
  localparam int PROD_W    = tsa_pkg::PROD_W;
  localparam int CROSS_W   = tsa_pkg::CROSS_W;
  localparam int DOT_W     = tsa_pkg::DOT_W;
  localparam int NUMP_W    = tsa_pkg::NUMP_W;
  localparam int WIDE_W    = tsa_pkg::WIDE_W;
  localparam int MAG_W     = tsa_pkg::MAG_W;
  localparam int LEN_W     = tsa_pkg::LEN_W;
  localparam int LEN_GUARD = tsa_pkg::LEN_GUARD;
  localparam int CW        = tsa_pkg::CORDIC_W;
  localparam int ANG_W     = tsa_pkg::ANG_W;
  localparam int OUT_W     = tsa_pkg::OUT_W;

  // pipeline timing
  localparam int LMAG    = CORDIC_STEPS + 3;       // one magnitude pass
  localparam int P_LEN   = 4 + 2 * LMAG;           // lengths registered
  localparam int TOTAL   = P_LEN + 6 + CORDIC_STEPS;
  localparam int DOT_DLY = 2 * LMAG - 1;
  localparam int NUM_DLY = 2 * LMAG;
  localparam int RND_SH  = 30 - FRAC_BITS;
  localparam int AW2     = ANG_W + 2;

  localparam logic signed [AW2-1:0] SAT_HI = AW2'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [AW2-1:0] SAT_LO = -AW2'(2 ** (OUT_W - 1));

  // ---------------------------------------------------------------- config
  logic signed [COORD_W-1:0] obs_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_q[0] <= '0;
      obs_q[1] <= '0;
      obs_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tsa_pkg::CFG_OBS_X: obs_q[0] <= cfg_data_i;
        tsa_pkg::CFG_OBS_Y: obs_q[1] <= cfg_data_i;
        tsa_pkg::CFG_OBS_Z: obs_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------ flow control
  logic             adv;
  logic [TOTAL-1:0] vld_q;

  assign adv        = !(vld_q[TOTAL-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[TOTAL-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------- stage 1: r = v - obs
  logic signed [COORD_W-1:0] vin [9];
  logic signed [DIFF_W-1:0]  diff_d [9];
  logic signed [DIFF_W-1:0]  r1_q [9];

  assign vin[0] = in_data_i.first_x;
  assign vin[1] = in_data_i.first_y;
  assign vin[2] = in_data_i.first_z;
  assign vin[3] = in_data_i.second_x;
  assign vin[4] = in_data_i.second_y;
  assign vin[5] = in_data_i.second_z;
  assign vin[6] = in_data_i.third_x;
  assign vin[7] = in_data_i.third_y;
  assign vin[8] = in_data_i.third_z;

  for (genvar k = 0; k < 9; k++) begin : g_diff
    assign diff_d[k] = DIFF_W'(vin[k]) - DIFF_W'(obs_q[k % 3]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) r1_q <= diff_d;
  end

  // ------------------------------------ stage 2: common exponent search
  logic [DIFF_W-1:0]        mag_or;
  logic signed [DIFF_W-1:0] r2_q [9];
  logic [6:0]               b2_q;

  always_comb begin
    mag_or = '0;
    for (int k = 0; k < 9; k++) begin
      mag_or = mag_or | (r1_q[k][DIFF_W-1] ? DIFF_W'(-r1_q[k]) : DIFF_W'(r1_q[k]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r2_q <= r1_q;
      b2_q <= tsa_pkg::bit_len(64'(mag_or));
    end
  end

  // ------------------------------------------ stage 3: block normalize
  logic signed [DIFF_W-1:0] shr [9];
  logic signed [R_W-1:0]    rn_d [9];
  logic signed [R_W-1:0]    rn_q [9];

  for (genvar k = 0; k < 9; k++) begin : g_norm
    assign shr[k]  = r2_q[k] >>> (b2_q - 7'(tsa_pkg::R_TOP));
    assign rn_d[k] = (b2_q > 7'(tsa_pkg::R_TOP)) ? shr[k][R_W-1:0]
                   : (r2_q[k][R_W-1:0] << (7'(tsa_pkg::R_TOP) - b2_q));
  end

  always_ff @(posedge clk_i) begin
    if (adv) rn_q <= rn_d;
  end

  // ------------------------------- stages 4..7: cross, dots, numerator
  logic signed [PROD_W-1:0]  pc_q [6];
  logic signed [PROD_W-1:0]  pd_q [9];
  logic signed [R_W-1:0]     ra4_q [3];
  logic signed [R_W-1:0]     ra5_q [3];
  logic signed [CROSS_W-1:0] c_q [3];
  logic signed [DOT_W-1:0]   dt_q [3];   // r2.r3, r3.r1, r1.r2
  logic signed [NUMP_W-1:0]  pn_q [3];
  logic signed [WIDE_W-1:0]  num_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pc_q[0] <= rn_q[4] * rn_q[8];
      pc_q[1] <= rn_q[5] * rn_q[7];
      pc_q[2] <= rn_q[5] * rn_q[6];
      pc_q[3] <= rn_q[3] * rn_q[8];
      pc_q[4] <= rn_q[3] * rn_q[7];
      pc_q[5] <= rn_q[4] * rn_q[6];
      pd_q[0] <= rn_q[3] * rn_q[6];
      pd_q[1] <= rn_q[4] * rn_q[7];
      pd_q[2] <= rn_q[5] * rn_q[8];
      pd_q[3] <= rn_q[6] * rn_q[0];
      pd_q[4] <= rn_q[7] * rn_q[1];
      pd_q[5] <= rn_q[8] * rn_q[2];
      pd_q[6] <= rn_q[0] * rn_q[3];
      pd_q[7] <= rn_q[1] * rn_q[4];
      pd_q[8] <= rn_q[2] * rn_q[5];
      ra4_q   <= rn_q[0:2];

      c_q[0]  <= CROSS_W'(pc_q[0]) - CROSS_W'(pc_q[1]);
      c_q[1]  <= CROSS_W'(pc_q[2]) - CROSS_W'(pc_q[3]);
      c_q[2]  <= CROSS_W'(pc_q[4]) - CROSS_W'(pc_q[5]);
      for (int j = 0; j < 3; j++) begin
        dt_q[j] <= DOT_W'(pd_q[3*j]) + DOT_W'(pd_q[3*j+1]) + DOT_W'(pd_q[3*j+2]);
      end
      ra5_q   <= ra4_q;

      for (int j = 0; j < 3; j++) begin
        pn_q[j] <= ra5_q[j] * c_q[j];
      end

      num_q <= WIDE_W'(pn_q[0]) + WIDE_W'(pn_q[1]) + WIDE_W'(pn_q[2]);
    end
  end

  // ------------------------------------------ lengths: two CORDIC passes
  logic signed [R_W-1:0]   zd_q [LMAG][3];
  logic signed [MAG_W-1:0] m1 [3];
  logic signed [MAG_W-1:0] m2 [3];
  logic signed [MAG_W:0]   lsum [3];
  logic signed [LEN_W-1:0] len_q [3];

  function automatic logic signed [MAG_W-1:0] guard(input logic signed [R_W-1:0] v);
    return {{(MAG_W - R_W - LEN_GUARD){v[R_W-1]}}, v, {LEN_GUARD{1'b0}}};
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int v = 0; v < 3; v++) begin
        zd_q[0][v] <= rn_q[3*v+2];
      end
      for (int j = 1; j < LMAG; j++) begin
        zd_q[j] <= zd_q[j-1];
      end
    end
  end

  for (genvar v = 0; v < 3; v++) begin : g_len
    tsa_cordic_mag #(
      .STEPS(CORDIC_STEPS)
    ) u_mag_xy (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (guard(rn_q[3*v])),
      .b_i   (guard(rn_q[3*v+1])),
      .mag_o (m1[v])
    );

    tsa_cordic_mag #(
      .STEPS(CORDIC_STEPS)
    ) u_mag_z (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (m1[v]),
      .b_i   (guard(zd_q[LMAG-1][v])),
      .mag_o (m2[v])
    );

    assign lsum[v] = (MAG_W+1)'(m2[v]) + (MAG_W+1)'(1 << (LEN_GUARD - 1));

    always_ff @(posedge clk_i) begin
      if (adv) len_q[v] <= lsum[v][LEN_GUARD+LEN_W-1:LEN_GUARD];
    end
  end

  // ----------------------------- align dots and numerator with lengths
  logic signed [DOT_W-1:0]  dd_q [DOT_DLY][3];
  logic signed [WIDE_W-1:0] nd_q [NUM_DLY];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd_q[0] <= dt_q;
      for (int j = 1; j < DOT_DLY; j++) dd_q[j] <= dd_q[j-1];
      nd_q[0] <= num_q;
      for (int j = 1; j < NUM_DLY; j++) nd_q[j] <= nd_q[j-1];
    end
  end

  // --------------------------------------------- denominator, 3 stages
  logic signed [2*LEN_W-1:0]       p12_q;
  logic signed [LEN_W-1:0]         n3a_q;
  logic signed [WIDE_W-1:0]        q_q [3];
  logic signed [3*LEN_W-1:0]       p123_w;
  logic signed [WIDE_W-1:0]        p123_q;
  logic signed [WIDE_W-1:0]        qs_q;
  logic signed [WIDE_W-1:0]        den_q;

  assign p123_w = p12_q * n3a_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p12_q  <= len_q[0] * len_q[1];
      n3a_q  <= len_q[2];
      q_q[0] <= len_q[0] * dd_q[DOT_DLY-1][0];
      q_q[1] <= len_q[1] * dd_q[DOT_DLY-1][1];
      q_q[2] <= len_q[2] * dd_q[DOT_DLY-1][2];

      p123_q <= p123_w[WIDE_W-1:0];
      qs_q   <= q_q[0] + q_q[1] + q_q[2];

      den_q  <= p123_q + qs_q;
    end
  end

  // ------------------------------ atan2 operand normalize and quadrant
  logic [WIDE_W-1:0]        den_mag, num_mag;
  logic signed [WIDE_W-1:0] denD_q, numD_q;
  logic [6:0]               blD_q;
  logic                     degD_q;

  assign den_mag = den_q[WIDE_W-1] ? WIDE_W'(-den_q) : WIDE_W'(den_q);
  assign num_mag = nd_q[NUM_DLY-1][WIDE_W-1] ? WIDE_W'(-nd_q[NUM_DLY-1])
                 : WIDE_W'(nd_q[NUM_DLY-1]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      denD_q <= den_q;
      numD_q <= nd_q[NUM_DLY-1];
      blD_q  <= tsa_pkg::bit_len(den_mag | num_mag);
      degD_q <= (den_q == '0) && (nd_q[NUM_DLY-1] == '0);
    end
  end

  logic signed [WIDE_W-1:0] dsh, nsh;
  logic signed [CW-1:0]     xs, ys;
  logic signed [CW-1:0]     xe_q, ye_q;
  logic signed [ANG_W-1:0]  ze_q;
  logic                     dege_q;

  always_comb begin
    if (blD_q > 7'(tsa_pkg::ATAN_TOP)) begin
      dsh = denD_q >>> (blD_q - 7'(tsa_pkg::ATAN_TOP));
      nsh = numD_q >>> (blD_q - 7'(tsa_pkg::ATAN_TOP));
    end else begin
      dsh = denD_q << (7'(tsa_pkg::ATAN_TOP) - blD_q);
      nsh = numD_q << (7'(tsa_pkg::ATAN_TOP) - blD_q);
    end
    xs = dsh[CW-1:0];
    ys = nsh[CW-1:0];
  end

  // negative denominator: flip the vector and start from +/- pi
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dege_q <= degD_q;
      if (xs < 0) begin
        xe_q <= -xs;
        ye_q <= -ys;
        ze_q <= (ys >= 0) ? tsa_pkg::PI_Q30 : -tsa_pkg::PI_Q30;
      end else begin
        xe_q <= xs;
        ye_q <= ys;
        ze_q <= '0;
      end
    end
  end

  // ----------------------------------------------------- atan2 CORDIC
  logic signed [ANG_W-1:0] z_fin;
  logic                    dg_q [CORDIC_STEPS];

  tsa_cordic_atan #(
    .STEPS(CORDIC_STEPS)
  ) u_atan (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (xe_q),
    .y_i   (ye_q),
    .z_i   (ze_q),
    .z_o   (z_fin)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dg_q[0] <= dege_q;
      for (int j = 1; j < CORDIC_STEPS; j++) dg_q[j] <= dg_q[j-1];
    end
  end

  // ---------------------------------- double, round, saturate, output
  logic signed [AW2-1:0] twice_z, ang_w, ang_sat;
  tsa_pkg::out_t         out_q;

  always_comb begin
    twice_z = {z_fin[ANG_W-1], z_fin, 1'b0};
    ang_w   = (twice_z + (AW2'(1) <<< (RND_SH - 1))) >>> RND_SH;
    if (ang_w > SAT_HI) begin
      ang_sat = SAT_HI;
    end else if (ang_w < SAT_LO) begin
      ang_sat = SAT_LO;
    end else begin
      ang_sat = ang_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.degenerate  <= dg_q[CORDIC_STEPS-1];
      out_q.solid_angle <= dg_q[CORDIC_STEPS-1] ? '0 : ang_sat[OUT_W-1:0];
    end
  end

  assign out_valid_o = vld_q[TOTAL-1];
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // a degenerate face always reports a zero angle
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |-> out_data_o.solid_angle == '0)
    else $error("degenerate transaction with nonzero angle");

  // a held result freezes every stage
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(vld_q) && $stable(out_data_o))
    else $error("pipeline moved while output stalled");

  // input is refused only while a result is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");
`endif

endmodule
